/* src/uv_sphere_tessellator_macros.svh */
// Assertion macros of the tessellator RTL, used by the output register.
`ifndef UV_SPHERE_TESSELLATOR_MACROS_SVH
`define UV_SPHERE_TESSELLATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UVST_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UVST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/uvst_pkg.sv */
// Types, constants and arithmetic helpers of the UV-sphere tessellator.
`default_nettype none

package uvst_pkg;

  // Angle multipliers and the texture split below assume a level of at most 4.
  localparam int unsigned MAX_DETAIL = 4;

  typedef enum logic [0:0] {
    REG_DETAIL = 1'b0,
    REG_RADIUS = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    CMD_VERTEX = 1'b0,
    CMD_QUAD   = 1'b1
  } cmd_e;

  // Fields that ride along the pipeline untouched.
  typedef struct packed {
    logic        quad;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [11:0] first;
    logic [11:0] second;
  } side_t;

  typedef struct packed {
    side_t      side;
    logic [7:0] th;
    logic [7:0] ph;
  } angle_t;

  typedef struct packed {
    side_t              side;
    logic signed [15:0] st;
    logic signed [15:0] ct;
    logic signed [15:0] sp;
    logic signed [15:0] cp;
  } trig_t;

  typedef struct packed {
    side_t              side;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } norm_t;

  typedef struct packed {
    side_t              side;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [16:0] px;
    logic signed [16:0] py;
    logic signed [16:0] pz;
  } vert_t;

  function automatic logic [2:0] eff_detail(input logic [2:0] d);
    if (d == 3'd0) return 3'd1;
    if (d > 3'(MAX_DETAIL)) return 3'(MAX_DETAIL);
    return d;
  endfunction

  // Steps of pi/96 per grid index: 12/d.
  function automatic logic [3:0] angle_mult(input logic [2:0] d);
    logic [3:0] m;
    case (d)
      3'd1:    m = 4'd12;
      3'd2:    m = 4'd6;
      3'd3:    m = 4'd4;
      3'd4:    m = 4'd3;
      default: m = 4'd12;
    endcase
    return m;
  endfunction

  // sin(i*pi/96) in Q1.14 for i = 0..48.
  function automatic logic [14:0] quarter_sine(input logic [5:0] i);
    logic [14:0] v;
    case (i)
      6'd0:  v = 15'd0;     6'd1:  v = 15'd536;   6'd2:  v = 15'd1072;
      6'd3:  v = 15'd1606;  6'd4:  v = 15'd2139;  6'd5:  v = 15'd2669;
      6'd6:  v = 15'd3196;  6'd7:  v = 15'd3720;  6'd8:  v = 15'd4240;
      6'd9:  v = 15'd4756;  6'd10: v = 15'd5266;  6'd11: v = 15'd5771;
      6'd12: v = 15'd6270;  6'd13: v = 15'd6762;  6'd14: v = 15'd7246;
      6'd15: v = 15'd7723;  6'd16: v = 15'd8192;  6'd17: v = 15'd8652;
      6'd18: v = 15'd9102;  6'd19: v = 15'd9543;  6'd20: v = 15'd9974;
      6'd21: v = 15'd10394; 6'd22: v = 15'd10803; 6'd23: v = 15'd11200;
      6'd24: v = 15'd11585; 6'd25: v = 15'd11963; 6'd26: v = 15'd12318;
      6'd27: v = 15'd12665; 6'd28: v = 15'd12998; 6'd29: v = 15'd13318;
      6'd30: v = 15'd13623; 6'd31: v = 15'd13913; 6'd32: v = 15'd14189;
      6'd33: v = 15'd14449; 6'd34: v = 15'd14694; 6'd35: v = 15'd14924;
      6'd36: v = 15'd15137; 6'd37: v = 15'd15334; 6'd38: v = 15'd15515;
      6'd39: v = 15'd15679; 6'd40: v = 15'd15826; 6'd41: v = 15'd15956;
      6'd42: v = 15'd16069; 6'd43: v = 15'd16165; 6'd44: v = 15'd16244;
      6'd45: v = 15'd16305; 6'd46: v = 15'd16349; 6'd47: v = 15'd16375;
      6'd48: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // Fold an angle index back into one turn (0..191).
  function automatic logic [7:0] wrap_turn(input logic [7:0] a);
    return (a >= 8'd192) ? 8'(a - 8'd192) : a;
  endfunction

  // sin(a*pi/96) in Q1.14, a in 0..191.
  function automatic logic signed [15:0] sine_q14(input logic [7:0] a);
    logic [1:0]  q;
    logic [5:0]  r;
    logic [14:0] m;
    if (a < 8'd48) begin
      q = 2'd0;
      r = a[5:0];
    end else if (a < 8'd96) begin
      q = 2'd1;
      r = 6'(a - 8'd48);
    end else if (a < 8'd144) begin
      q = 2'd2;
      r = 6'(a - 8'd96);
    end else begin
      q = 2'd3;
      r = 6'(a - 8'd144);
    end
    m = q[0] ? quarter_sine(6'd48 - r) : quarter_sine(r);
    return q[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // v / 2^14 rounded to nearest, ties away from zero.
  function automatic logic signed [20:0] round_q14(input logic signed [33:0] v);
    logic [33:0] mag;
    logic [33:0] sum;
    logic [19:0] sh;
    mag = v[33] ? 34'(-v) : 34'(v);
    sum = mag + 34'd8192;
    sh  = sum[33:14];
    return v[33] ? -$signed({1'b0, sh}) : $signed({1'b0, sh});
  endfunction

  // 65536 - round(idx*65536/count), count = 16d for longitude, 8d for latitude.
  function automatic logic [16:0] tex_coord(input logic [6:0] idx, input logic [2:0] d,
                                            input logic is_lon);
    logic [14:0] prod;
    logic [5:0]  q;
    logic [1:0]  r;
    logic [12:0] frac;
    logic [19:0] part;
    // idx/3 by reciprocal; exact for the index range here
    prod = 15'(idx) * 15'd171;
    q    = prod[14:9];
    r    = 2'(idx - 7'(q) * 7'd3);
    frac = 13'd0;
    case (d)
      3'd1: part = is_lon ? (20'(idx) << 12) : (20'(idx) << 13);
      3'd2: part = is_lon ? (20'(idx) << 11) : (20'(idx) << 12);
      3'd4: part = is_lon ? (20'(idx) << 10) : (20'(idx) << 11);
      3'd3: begin
        case (r)
          2'd1:    frac = is_lon ? 13'd1365 : 13'd2731;
          2'd2:    frac = is_lon ? 13'd2731 : 13'd5461;
          default: frac = 13'd0;
        endcase
        part = (is_lon ? (20'(q) << 12) : (20'(q) << 13)) + 20'(frac);
      end
      default: part = 20'd0;
    endcase
    return 17'(20'd65536 - part);
  endfunction

endpackage

`default_nettype wire

/* src/uv_sphere_tessellator.sv */
// Top level of the UV-sphere tessellator: configuration registers and pipeline.
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_stall_o  | command, lat_index, lon_index
//   out     | output    | out_valid_o / out_stall_i| position, normal, texcoord, corners
//   cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// Five register stages (front, sine lookup, normal, scale, output); one vertex
// command is taken per cycle while the output is not stalled and no quad is pending.
// A quad command occupies the output register for both of its triangles, so the
// input is stalled while its second triangle is pending. A stall on a waiting result freezes all stages.
// Reset clears valid bits and loads detail 1, radius 1.0; the block is ready
// as soon as reset is released.
`default_nettype none

module uv_sphere_tessellator (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                command_i,
  input  wire logic [5:0]          lat_index_i,
  input  wire logic [6:0]          lon_index_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [16:0]       pos_x_o,
  output logic signed [16:0]       pos_y_o,
  output logic signed [16:0]       pos_z_o,
  output logic signed [15:0]       norm_x_o,
  output logic signed [15:0]       norm_y_o,
  output logic signed [15:0]       norm_z_o,
  output logic [16:0]              tex_u_o,
  output logic [16:0]              tex_v_o,
  output logic [11:0]              corner_a_o,
  output logic [11:0]              corner_b_o,
  output logic [11:0]              corner_c_o,
  output logic                     last_of_run_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [0:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i
);

  logic [2:0]       detail_q;
  logic [15:0]      radius_q;
  logic             advance;
  logic             front_valid;
  logic             norm_valid;
  logic             vert_valid;
  uvst_pkg::angle_t front_data;
  uvst_pkg::norm_t  norm_data;
  uvst_pkg::vert_t  vert_data;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detail_q <= 3'd1;
      radius_q <= 16'd256;
    end else if (cfg_valid_i) begin
      unique case (uvst_pkg::cfg_reg_e'(cfg_index_i))
        uvst_pkg::REG_DETAIL: detail_q <= cfg_data_i[2:0];
        uvst_pkg::REG_RADIUS: radius_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  uvst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .valid_i     (in_valid_i),
    .command_i   (command_i),
    .lat_index_i (lat_index_i),
    .lon_index_i (lon_index_i),
    .detail_i    (detail_q),
    .valid_o     (front_valid),
    .data_o      (front_data)
  );

  uvst_trig u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (front_valid),
    .data_i  (front_data),
    .valid_o (norm_valid),
    .data_o  (norm_data)
  );

  uvst_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .valid_i  (norm_valid),
    .data_i   (norm_data),
    .radius_i (radius_q),
    .valid_o  (vert_valid),
    .data_o   (vert_data)
  );

  uvst_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (vert_valid),
    .data_i        (vert_data),
    .out_stall_i   (out_stall_i),
    .advance_o     (advance),
    .out_valid_o   (out_valid_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pos_z_o       (pos_z_o),
    .norm_x_o      (norm_x_o),
    .norm_y_o      (norm_y_o),
    .norm_z_o      (norm_z_o),
    .tex_u_o       (tex_u_o),
    .tex_v_o       (tex_v_o),
    .corner_a_o    (corner_a_o),
    .corner_b_o    (corner_b_o),
    .corner_c_o    (corner_c_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire

/* src/uvst_front.sv */
// Front stage: clamp indices, angle steps, texture coordinates and quad corners.
`default_nettype none

module uvst_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic                 command_i,
  input  wire logic [5:0]           lat_index_i,
  input  wire logic [6:0]           lon_index_i,
  input  wire logic [2:0]           detail_i,
  output logic                      valid_o,
  output uvst_pkg::angle_t          data_o
);

  logic [2:0]       d;
  logic [5:0]       bands;
  logic [6:0]       segs;
  logic [6:0]       seg_stride;
  logic             quad;
  logic [5:0]       lat_lim;
  logic [6:0]       lon_lim;
  logic [5:0]       lat_c;
  logic [6:0]       lon_c;
  logic [3:0]       mult;
  logic [9:0]       th_full;
  logic [10:0]      ph_full;
  logic [12:0]      first_full;
  logic [11:0]      first;
  logic             valid_q;
  uvst_pkg::angle_t data_d, data_q;

  always_comb begin
    d          = uvst_pkg::eff_detail(detail_i);
    bands      = {d, 3'b000};
    segs       = {d, 4'b0000};
    seg_stride = segs + 7'd1;
    quad       = (uvst_pkg::cmd_e'(command_i) == uvst_pkg::CMD_QUAD);
    lat_lim    = quad ? bands - 6'd1 : bands;
    lon_lim    = quad ? segs - 7'd1 : segs;
    lat_c      = (lat_index_i > lat_lim) ? lat_lim : lat_index_i;
    lon_c      = (lon_index_i > lon_lim) ? lon_lim : lon_index_i;
    mult       = uvst_pkg::angle_mult(d);
    th_full    = 10'(lat_c) * 10'(mult);
    ph_full    = 11'(lon_c) * 11'(mult);
    first_full = 13'(lat_c) * 13'(seg_stride) + 13'(lon_c);
    first      = first_full[11:0];

    data_d.th          = th_full[7:0];
    data_d.ph          = ph_full[7:0];
    data_d.side.quad   = quad;
    data_d.side.tex_u  = uvst_pkg::tex_coord(lon_c, d, 1'b1);
    data_d.side.tex_v  = uvst_pkg::tex_coord({1'b0, lat_c}, d, 1'b0);
    data_d.side.first  = first;
    data_d.side.second = first + 12'(seg_stride);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* src/uvst_trig.sv */
// Trig stages: quarter-wave sine lookup, then the rounded unit normal.
`default_nettype none

module uvst_trig (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire uvst_pkg::angle_t  data_i,
  output logic                   valid_o,
  output uvst_pkg::norm_t        data_o
);

  uvst_pkg::trig_t    trig_d, trig_q;
  uvst_pkg::norm_t    norm_d, norm_q;
  logic               trig_valid_q;
  logic               norm_valid_q;
  logic signed [31:0] prod_x;
  logic signed [31:0] prod_z;
  logic signed [20:0] nx_full;
  logic signed [20:0] nz_full;

  // Lookup stage: cosine is sine a quarter turn ahead.
  always_comb begin
    trig_d.side = data_i.side;
    trig_d.st   = uvst_pkg::sine_q14(data_i.th);
    trig_d.ct   = uvst_pkg::sine_q14(uvst_pkg::wrap_turn(data_i.th + 8'd48));
    trig_d.sp   = uvst_pkg::sine_q14(data_i.ph);
    trig_d.cp   = uvst_pkg::sine_q14(uvst_pkg::wrap_turn(data_i.ph + 8'd48));
  end

  // Normal stage.
  always_comb begin
    prod_x      = trig_q.cp * trig_q.st;
    prod_z      = trig_q.sp * trig_q.st;
    nx_full     = uvst_pkg::round_q14({{2{prod_x[31]}}, prod_x});
    nz_full     = uvst_pkg::round_q14({{2{prod_z[31]}}, prod_z});
    norm_d.side = trig_q.side;
    norm_d.nx   = nx_full[15:0];
    norm_d.ny   = trig_q.ct;
    norm_d.nz   = nz_full[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_valid_q <= 1'b0;
      norm_valid_q <= 1'b0;
    end else if (en_i) begin
      trig_valid_q <= valid_i;
      norm_valid_q <= trig_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_q <= trig_d;
      norm_q <= norm_d;
    end
  end

  assign valid_o = norm_valid_q;
  assign data_o  = norm_q;

endmodule

`default_nettype wire

/* src/uvst_scale.sv */
// Scale stage: position = radius * normal, rounded to Q8.8.
`default_nettype none

module uvst_scale (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire uvst_pkg::norm_t   data_i,
  input  wire logic [15:0]       radius_i,
  output logic                   valid_o,
  output uvst_pkg::vert_t        data_o
);

  logic signed [16:0] rad_s;
  logic signed [32:0] prod_x, prod_y, prod_z;
  logic signed [20:0] px_full, py_full, pz_full;
  logic               valid_q;
  uvst_pkg::vert_t    data_d, data_q;

  always_comb begin
    rad_s       = $signed({1'b0, radius_i});
    prod_x      = rad_s * data_i.nx;
    prod_y      = rad_s * data_i.ny;
    prod_z      = rad_s * data_i.nz;
    px_full     = uvst_pkg::round_q14({prod_x[32], prod_x});
    py_full     = uvst_pkg::round_q14({prod_y[32], prod_y});
    pz_full     = uvst_pkg::round_q14({prod_z[32], prod_z});
    data_d.side = data_i.side;
    data_d.nx   = data_i.nx;
    data_d.ny   = data_i.ny;
    data_d.nz   = data_i.nz;
    data_d.px   = px_full[16:0];
    data_d.py   = py_full[16:0];
    data_d.pz   = pz_full[16:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* src/uvst_out.sv */
// Output register: emits vertices and splits a quad into its two triangles.
`default_nettype none

`include "uv_sphere_tessellator_macros.svh"

module uvst_out (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire uvst_pkg::vert_t     data_i,
  input  wire logic                out_stall_i,
  output logic                     advance_o,
  output logic                     out_valid_o,
  output logic signed [16:0]       pos_x_o,
  output logic signed [16:0]       pos_y_o,
  output logic signed [16:0]       pos_z_o,
  output logic signed [15:0]       norm_x_o,
  output logic signed [15:0]       norm_y_o,
  output logic signed [15:0]       norm_z_o,
  output logic [16:0]              tex_u_o,
  output logic [16:0]              tex_v_o,
  output logic [11:0]              corner_a_o,
  output logic [11:0]              corner_b_o,
  output logic [11:0]              corner_c_o,
  output logic                     last_of_run_o
);

  logic               out_valid_q;
  logic               pend_q;
  logic               out_free;
  logic               advance;
  logic               last_q;
  logic signed [16:0] px_q, py_q, pz_q;
  logic signed [15:0] nx_q, ny_q, nz_q;
  logic [16:0]        tu_q, tv_q;
  logic [11:0]        ca_q, cb_q, cc_q;
  logic [11:0]        first_inc;

  assign out_free   = !out_valid_q || !out_stall_i;
  // Freeze the pipeline while the second triangle of a quad is pending.
  assign advance    = out_free && !pend_q;
  assign first_inc  = data_i.side.first + 12'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (out_free) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else begin
        out_valid_q <= valid_i;
        pend_q      <= valid_i && data_i.side.quad;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_q || data_i.side.quad) begin
        px_q <= '0;
        py_q <= '0;
        pz_q <= '0;
        nx_q <= '0;
        ny_q <= '0;
        nz_q <= '0;
        tu_q <= '0;
        tv_q <= '0;
        if (pend_q) begin
          // The quad has already left the pipeline: build the second
          // triangle from the corners of the first one.
          ca_q   <= cb_q;
          cb_q   <= cb_q + 12'd1;
          last_q <= 1'b1;
        end else begin
          ca_q   <= data_i.side.first;
          cb_q   <= data_i.side.second;
          cc_q   <= first_inc;
          last_q <= 1'b0;
        end
      end else begin
        px_q   <= data_i.px;
        py_q   <= data_i.py;
        pz_q   <= data_i.pz;
        nx_q   <= data_i.nx;
        ny_q   <= data_i.ny;
        nz_q   <= data_i.nz;
        tu_q   <= data_i.side.tex_u;
        tv_q   <= data_i.side.tex_v;
        ca_q   <= '0;
        cb_q   <= '0;
        cc_q   <= '0;
        last_q <= 1'b1;
      end
    end
  end

  assign advance_o     = advance;
  assign out_valid_o   = out_valid_q;
  assign pos_x_o       = px_q;
  assign pos_y_o       = py_q;
  assign pos_z_o       = pz_q;
  assign norm_x_o      = nx_q;
  assign norm_y_o      = ny_q;
  assign norm_z_o      = nz_q;
  assign tex_u_o       = tu_q;
  assign tex_v_o       = tv_q;
  assign corner_a_o    = ca_q;
  assign corner_b_o    = cb_q;
  assign corner_c_o    = cc_q;
  assign last_of_run_o = last_q;

  `UVST_ASSERT_HOLDS(a_pend_holds_first, clk_i, rst_ni, pend_q, out_valid_q && !last_q, "pending quad without first triangle held")
  `UVST_ASSERT_HOLDS(a_first_has_pend, clk_i, rst_ni, out_valid_q && !last_q, pend_q, "first triangle shown without second pending")
  `UVST_ASSERT_HOLDS(a_pend_freezes, clk_i, rst_ni, pend_q, !advance, "pipeline advanced during quad split")
  `UVST_ASSERT_NEXT(a_pend_then_last, clk_i, rst_ni, pend_q && !out_stall_i, out_valid_q && last_q && !pend_q, "second triangle not issued")

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the UV-sphere tessellator: directed table, then random phases.

module tb_top;

  typedef struct {
    logic signed [16:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic [16:0]        u, v;
    logic [11:0]        ca, cb, cc;
    logic               last;
  } mesh_out_t;

  typedef enum {ROW_SETUP, ROW_ITEM} row_kind_e;

  // Setup rows: f0 = detail, f1 = radius. Item rows: f0 = command, f1 = lat, f2 = lon.
  // known_idx selects typed results below, -1 hands the row to the predictor.
  typedef struct {
    row_kind_e kind;
    int        f0, f1, f2;
    int        known_idx;
  } row_t;

  localparam int PLAN_LEN = 25;
  localparam int PHASES   = 14;
  localparam int PER_PHASE = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        command_i = 1'b0;
  logic [5:0]  lat_index_i = '0;
  logic [6:0]  lon_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [16:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [15:0] norm_x_o, norm_y_o, norm_z_o;
  logic [16:0] tex_u_o, tex_v_o;
  logic [11:0] corner_a_o, corner_b_o, corner_c_o;
  logic        last_of_run_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  // Register copies seen by the predictor.
  logic [2:0]  detail_reg = 3'd1;
  logic [15:0] radius_reg = 16'd256;

  mesh_out_t awaited_mesh [$];
  int errors = 0;
  int results_seen = 0;
  int n_vertex = 0;
  int n_quad = 0;
  int n_settings = 0;
  int tx_calm_left = 0;
  int rx_left = 0;
  int rx_calm = 0;

  int quarter_wave [49] = '{
    0, 536, 1072, 1606, 2139, 2669, 3196, 3720, 4240, 4756,
    5266, 5771, 6270, 6762, 7246, 7723, 8192, 8652, 9102, 9543,
    9974, 10394, 10803, 11200, 11585, 11963, 12318, 12665, 12998, 13318,
    13623, 13913, 14189, 14449, 14694, 14924, 15137, 15334, 15515, 15679,
    15826, 15956, 16069, 16165, 16244, 16305, 16349, 16375, 16384
  };

  // Results under the reset setting (detail 1, radius 1.0).
  mesh_out_t known [7] = '{
    '{0, 256, 0, 0, 16384, 0, 65536, 65536, 0, 0, 0, 1},
    '{0, -256, 0, 0, -16384, 0, 0, 0, 0, 0, 0, 1},
    '{0, 0, 256, 0, 0, 16384, 49152, 32768, 0, 0, 0, 1},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 17, 1, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 17, 18, 1, 1},
    '{0, 0, 0, 0, 0, 0, 0, 0, 134, 151, 135, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 151, 152, 135, 1}
  };

  row_t plan [PLAN_LEN] = '{
    '{ROW_ITEM, uvst_pkg::CMD_VERTEX, 0, 0, 0},     // north pole
    '{ROW_ITEM, uvst_pkg::CMD_VERTEX, 8, 16, 1},    // south pole on the seam
    '{ROW_ITEM, uvst_pkg::CMD_VERTEX, 4, 4, 2},     // equator, quarter turn
    '{ROW_ITEM, uvst_pkg::CMD_VERTEX, 63, 127, 1},  // clamp to the south pole
    '{ROW_ITEM, uvst_pkg::CMD_QUAD, 0, 0, 3},
    '{ROW_ITEM, uvst_pkg::CMD_QUAD, 63, 127, 5},    // clamp to the last cell
    '{ROW_ITEM, uvst_pkg::CMD_QUAD, 7, 15, 5},
    '{ROW_SETUP, 3, 65535, 0, -1},                  // level three, largest radius
    '{ROW_ITEM, uvst_pkg::CMD_VERTEX, 1, 1, -1},
    '{ROW_ITEM, uvst_pkg::CMD_VERTEX, 5, 7, -1},
    '{ROW_ITEM, uvst_pkg::CMD_VERTEX, 24, 48, -1},
    '{ROW_ITEM, uvst_pkg::CMD_VERTEX, 25, 49, -1},
    '{ROW_ITEM, uvst_pkg::CMD_QUAD, 23, 47, -1},
    '{ROW_ITEM, uvst_pkg::CMD_QUAD, 40, 100, -1},
    '{ROW_SETUP, 0, 0, 0, -1},                      // level zero acts as one, radius zero
    '{ROW_ITEM, uvst_pkg::CMD_VERTEX, 3, 5, -1},
    '{ROW_ITEM, uvst_pkg::CMD_QUAD, 8, 16, -1},
    '{ROW_SETUP, 7, 384, 0, -1},                    // level above the maximum
    '{ROW_ITEM, uvst_pkg::CMD_VERTEX, 32, 64, -1},
    '{ROW_ITEM, uvst_pkg::CMD_VERTEX, 17, 33, -1},
    '{ROW_ITEM, uvst_pkg::CMD_QUAD, 31, 63, -1},
    '{ROW_ITEM, uvst_pkg::CMD_QUAD, 63, 127, -1},
    '{ROW_SETUP, 2, 1, 0, -1},
    '{ROW_ITEM, uvst_pkg::CMD_VERTEX, 9, 13, -1},
    '{ROW_ITEM, uvst_pkg::CMD_QUAD, 15, 31, -1}
  };

  uv_sphere_tessellator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .lat_index_i   (lat_index_i),
    .lon_index_i   (lon_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pos_z_o       (pos_z_o),
    .norm_x_o      (norm_x_o),
    .norm_y_o      (norm_y_o),
    .norm_z_o      (norm_z_o),
    .tex_u_o       (tex_u_o),
    .tex_v_o       (tex_v_o),
    .corner_a_o    (corner_a_o),
    .corner_b_o    (corner_b_o),
    .corner_c_o    (corner_c_o),
    .last_of_run_o (last_of_run_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned detail_used();
    if (detail_reg == 3'd0) return 1;
    if (detail_reg > 3'd4) return 4;
    return detail_reg;
  endfunction

  // sin(a * pi/96) in Q1.14
  function automatic longint sine_at(int unsigned a);
    int unsigned q;
    int unsigned r;
    longint m;
    a = a % 192;
    q = a / 48;
    r = a % 48;
    m = (q % 2 == 1) ? quarter_wave[48 - r] : quarter_wave[r];
    return (q >= 2) ? -m : m;
  endfunction

  // v / 2^14, rounded half away from zero
  function automatic longint div_q14(longint v);
    return (v >= 0) ? ((v + 8192) >>> 14) : -((-v + 8192) >>> 14);
  endfunction

  // Append one expected result.
  function automatic void expect_result(mesh_out_t r);
    awaited_mesh = {awaited_mesh, r};
  endfunction

  function automatic void tessellate(uvst_pkg::cmd_e cmd, logic [5:0] lat_in,
                                     logic [6:0] lon_in);
    int unsigned d, bands, segs, lat, lon, th, ph, first, second;
    longint st, ct, sp, cp;
    longint n [3];
    mesh_out_t r;
    d = detail_used();
    bands = 8 * d;
    segs = 16 * d;
    lat = lat_in;
    lon = lon_in;
    r = '{default: '0};
    if (cmd == uvst_pkg::CMD_VERTEX) begin
      if (lat > bands) lat = bands;
      if (lon > segs) lon = segs;
      th = (lat * 24 + d) / (2 * d);
      ph = (lon * 24 + d) / (2 * d);
      st = sine_at(th);
      ct = sine_at(th + 48);
      sp = sine_at(ph);
      cp = sine_at(ph + 48);
      n[0] = div_q14(cp * st);
      n[1] = ct;
      n[2] = div_q14(sp * st);
      r.nx = 16'(n[0]);
      r.ny = 16'(n[1]);
      r.nz = 16'(n[2]);
      r.px = 17'(div_q14(longint'(radius_reg) * n[0]));
      r.py = 17'(div_q14(longint'(radius_reg) * n[1]));
      r.pz = 17'(div_q14(longint'(radius_reg) * n[2]));
      r.u = 17'(65536 - (lon * 131072 + segs) / (2 * segs));
      r.v = 17'(65536 - (lat * 131072 + bands) / (2 * bands));
      r.last = 1'b1;
      expect_result(r);
    end else begin
      if (lat > bands - 1) lat = bands - 1;
      if (lon > segs - 1) lon = segs - 1;
      first = lat * (segs + 1) + lon;
      second = first + segs + 1;
      r.ca = 12'(first);
      r.cb = 12'(second);
      r.cc = 12'(first + 1);
      r.last = 1'b0;
      expect_result(r);
      r.ca = 12'(second);
      r.cb = 12'(second + 1);
      r.last = 1'b1;
      expect_result(r);
    end
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [15:0] pick_radius();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(128, 1024));
    endcase
  endfunction

  task automatic send_item(uvst_pkg::cmd_e cmd, logic [5:0] lat, logic [6:0] lon,
                           int known_idx);
    int gap;
    if (tx_calm_left > 0) begin
      tx_calm_left--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 29) == 0) tx_calm_left = $urandom_range(10, 60);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    lat_index_i <= lat;
    lon_index_i <= lon;
    do @(posedge clk_i); while (in_stall_o);
    // transaction taken at this edge
    if (known_idx >= 0) begin
      expect_result(known[known_idx]);
      if (cmd == uvst_pkg::CMD_QUAD) expect_result(known[known_idx + 1]);
    end else begin
      tessellate(cmd, lat, lon);
    end
    if (cmd == uvst_pkg::CMD_QUAD) n_quad++;
    else n_vertex++;
  endtask

  // Drop valid and hold until every expected result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (awaited_mesh.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_config(logic [15:0] detail_data, logic [15:0] radius_data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= uvst_pkg::REG_DETAIL;
    cfg_data_i <= detail_data;
    do @(posedge clk_i); while (!cfg_ready_o);
    detail_reg = detail_data[2:0];
    cfg_index_i <= uvst_pkg::REG_RADIUS;
    cfg_data_i <= radius_data;
    do @(posedge clk_i); while (!cfg_ready_o);
    radius_reg = radius_data;
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Receiver: random stall bursts with calm stretches.
  always @(posedge clk_i) begin
    logic stall_now;
    stall_now = 1'b0;
    if (rx_left > 0) begin
      rx_left--;
      stall_now = 1'b1;
    end else if (rx_calm > 0) begin
      rx_calm--;
    end else if ($urandom_range(0, 2) == 0) begin
      rx_left = pick_gap();
      if (rx_left > 0) begin
        stall_now = 1'b1;
        rx_left--;
      end
    end else if ($urandom_range(0, 49) == 0) begin
      rx_calm = $urandom_range(20, 80);
    end
    out_stall_i <= stall_now;
  end

  always @(posedge clk_i) begin
    mesh_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_mesh.size() == 0) begin
        $display("%0t: result with none expected (corners %0d %0d %0d)", $time,
                 corner_a_o, corner_b_o, corner_c_o);
        errors++;
      end else begin
        want = awaited_mesh.pop_front();
        check_field("pos_x", want.px, pos_x_o);
        check_field("pos_y", want.py, pos_y_o);
        check_field("pos_z", want.pz, pos_z_o);
        check_field("norm_x", want.nx, norm_x_o);
        check_field("norm_y", want.ny, norm_y_o);
        check_field("norm_z", want.nz, norm_z_o);
        check_field("tex_u", want.u, tex_u_o);
        check_field("tex_v", want.v, tex_v_o);
        check_field("corner_a", want.ca, corner_a_o);
        check_field("corner_b", want.cb, corner_b_o);
        check_field("corner_c", want.cc, corner_c_o);
        check_field("last_of_run", want.last, last_of_run_o);
        results_seen++;
      end
    end
  end

  initial begin
    uvst_pkg::cmd_e cmd;
    int unsigned bands, segs, lat, lon;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SETUP) begin
        drain();
        write_config(16'(plan[i].f0), 16'(plan[i].f1));
      end else begin
        send_item(uvst_pkg::cmd_e'(plan[i].f0), 6'(plan[i].f1), 7'(plan[i].f2),
                  plan[i].known_idx);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_config(16'($urandom_range(0, 65535)), pick_radius());
      bands = 8 * detail_used();
      segs = 16 * detail_used();
      for (int k = 0; k < PER_PHASE; k++) begin
        // hold the sender once mid-phase until the pipeline is empty
        if (p == PHASES / 2 && k == PER_PHASE / 2) drain();
        cmd = uvst_pkg::cmd_e'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 85) begin
          lat = $urandom_range(0, bands);
          lon = $urandom_range(0, segs);
        end else begin
          lat = $urandom_range(0, 63);
          lon = $urandom_range(0, 127);
        end
        send_item(cmd, 6'(lat), 7'(lon), -1);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d vertex and %0d quad commands over %0d register settings,",
             n_vertex, n_quad, n_settings);
    $display("%0d results compared, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", awaited_mesh.size());
    $display("status: fail");
    $finish;
  end

endmodule
